>>> hdl/ckic_pkg.sv
// Shared constants and keyword tables for the C keyword and identifier classifier.
package ckic_pkg;

  localparam int KW_COUNT  = 32;
  localparam int KW_MAXLEN = 8;
  localparam int CHAR_W    = 8;
  localparam int LEN_W     = 8;

  typedef logic [CHAR_W-1:0]          char_t;
  typedef logic [LEN_W-1:0]           len_t;
  typedef logic [KW_COUNT-1:0]        kw_mask_t;
  typedef logic [KW_MAXLEN*CHAR_W-1:0] kw_word_t;

  typedef enum logic [0:0] {
    CLASS_KEYWORD    = 1'b0,
    CLASS_IDENTIFIER = 1'b1
  } token_class_t;

  localparam char_t CH_LO_A  = 8'h61;  // 'a'
  localparam char_t CH_LO_Z  = 8'h7A;  // 'z'
  localparam char_t CH_UP_A  = 8'h41;  // 'A'
  localparam char_t CH_UP_Z  = 8'h5A;  // 'Z'
  localparam char_t CH_0     = 8'h30;  // '0'
  localparam char_t CH_9     = 8'h39;  // '9'
  localparam char_t CH_USCORE = 8'h5F; // '_'

  // Keyword lengths, one per candidate bit.
  function automatic logic [3:0] kw_len(input logic [4:0] k);
    logic [3:0] n;
    case (k)
      5'd0:  n = 4'd4;  5'd1:  n = 4'd7;  5'd2:  n = 4'd6;  5'd3:  n = 4'd4;
      5'd4:  n = 4'd6;  5'd5:  n = 4'd3;  5'd6:  n = 4'd8;  5'd7:  n = 4'd2;
      5'd8:  n = 4'd4;  5'd9:  n = 4'd3;  5'd10: n = 4'd5;  5'd11: n = 4'd2;
      5'd12: n = 4'd5;  5'd13: n = 4'd8;  5'd14: n = 4'd6;  5'd15: n = 4'd5;
      5'd16: n = 4'd6;  5'd17: n = 4'd4;  5'd18: n = 4'd4;  5'd19: n = 4'd5;
      5'd20: n = 4'd6;  5'd21: n = 4'd4;  5'd22: n = 4'd5;  5'd23: n = 4'd7;
      5'd24: n = 4'd6;  5'd25: n = 4'd8;  5'd26: n = 4'd4;  5'd27: n = 4'd6;
      5'd28: n = 4'd6;  5'd29: n = 4'd4;  5'd30: n = 4'd5;  5'd31: n = 4'd8;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

  // Keyword text, left-justified: the first character sits in the top byte.
  function automatic kw_word_t kw_word(input logic [4:0] k);
    kw_word_t w;
    case (k)
      5'd0:  w = kw_word_t'("auto");
      5'd1:  w = kw_word_t'("default");
      5'd2:  w = kw_word_t'("signed");
      5'd3:  w = kw_word_t'("enum");
      5'd4:  w = kw_word_t'("extern");
      5'd5:  w = kw_word_t'("for");
      5'd6:  w = kw_word_t'("register");
      5'd7:  w = kw_word_t'("if");
      5'd8:  w = kw_word_t'("else");
      5'd9:  w = kw_word_t'("int");
      5'd10: w = kw_word_t'("while");
      5'd11: w = kw_word_t'("do");
      5'd12: w = kw_word_t'("break");
      5'd13: w = kw_word_t'("continue");
      5'd14: w = kw_word_t'("double");
      5'd15: w = kw_word_t'("float");
      5'd16: w = kw_word_t'("return");
      5'd17: w = kw_word_t'("char");
      5'd18: w = kw_word_t'("case");
      5'd19: w = kw_word_t'("const");
      5'd20: w = kw_word_t'("sizeof");
      5'd21: w = kw_word_t'("long");
      5'd22: w = kw_word_t'("short");
      5'd23: w = kw_word_t'("typedef");
      5'd24: w = kw_word_t'("switch");
      5'd25: w = kw_word_t'("unsigned");
      5'd26: w = kw_word_t'("void");
      5'd27: w = kw_word_t'("static");
      5'd28: w = kw_word_t'("struct");
      5'd29: w = kw_word_t'("goto");
      5'd30: w = kw_word_t'("union");
      5'd31: w = kw_word_t'("volatile");
      default: w = '0;
    endcase
    return w << {3'(KW_MAXLEN - int'(kw_len(k))), 3'b000};
  endfunction

  // Character of keyword k at position pos (zero beyond its end).
  function automatic char_t kw_char(input logic [4:0] k, input logic [2:0] pos);
    kw_word_t w;
    w = kw_word(k);
    return w[{~pos, 3'b000} +: CHAR_W];
  endfunction

endpackage

>>> hdl/ckic_kw_match.sv
// Keyword candidate mask narrowing and end-of-token keyword hit detection.
module ckic_kw_match (
  input  ckic_pkg::char_t    ch,
  input  ckic_pkg::len_t     pos,
  input  ckic_pkg::kw_mask_t cand,
  output ckic_pkg::kw_mask_t cand_nxt,
  output logic               kw_hit
);

  ckic_pkg::kw_mask_t char_match;
  ckic_pkg::kw_mask_t len_match;

  // Each candidate bit is independent: position in range and character equal.
  always_comb begin
    for (int k = 0; k < ckic_pkg::KW_COUNT; k++) begin
      char_match[k] = (pos < ckic_pkg::len_t'(ckic_pkg::kw_len(5'(k)))) &&
                      (ckic_pkg::kw_char(5'(k), pos[2:0]) == ch);
      len_match[k]  = (pos == ckic_pkg::len_t'(ckic_pkg::kw_len(5'(k))));
    end
  end

  assign cand_nxt = cand & char_match;
  assign kw_hit   = |(cand & len_match);

endmodule

>>> hdl/c_keyword_identifier_classifier.sv
// Top level of the streaming C keyword and identifier classifier.
// The block takes one text byte per item and cuts the stream into tokens at
// whitespace (space, tab, newline, vertical tab, form feed, carriage return).
// An input item with in_tlast high ends the pending token without carrying a
// character. Each finished token that is one of the 32 C89 keywords is
// reported with out_tuser low; a token that is a valid identifier (letter or
// underscore first, then letters, digits or underscores) is reported with
// out_tuser high. Other tokens give no result. out_tdata holds the token
// length, saturating at 255. The block takes one item per clock cycle while
// no result waits for out_tready: an accepted item sits in the input
// register, then the keyword mask update and classification run
// combinationally and the result lands in the output register. Only the
// output register holds the flow: while a result waits for out_tready the
// pipeline holds, and it moves again in the cycle the result is taken.
// No token text is stored; a 32-bit candidate mask tracks which keywords
// still match.
module c_keyword_identifier_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] token_length
  output logic [0:0] out_tuser   // [0] token_class
);

  // Input register.
  logic              s1_valid_r;
  ckic_pkg::char_t   s1_ch_r;
  logic              s1_eot_r;

  // Token state.
  logic               in_token_r,  in_token_nxt;
  ckic_pkg::len_t     count_r,     count_nxt;
  logic               ident_ok_r,  ident_ok_nxt;
  ckic_pkg::kw_mask_t cand_r,      cand_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  ckic_pkg::token_class_t out_class_r, out_class_nxt;
  ckic_pkg::len_t         out_len_r,   out_len_nxt;

  logic               advance;
  logic               is_space;
  logic               is_alpha_us;
  logic               is_digit;
  logic               is_end;
  logic               kw_hit;
  ckic_pkg::kw_mask_t mask_upd;

  // The processing stage moves when it holds an item and the output register
  // is free or is being emptied in this cycle.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_ch_r  <= in_tdata;
      s1_eot_r <= in_tlast;
    end
  end

  always_comb begin
    is_space    = s1_ch_r inside {8'h20, [8'h09:8'h0D]};
    is_alpha_us = s1_ch_r inside {[ckic_pkg::CH_LO_A:ckic_pkg::CH_LO_Z],
                                  [ckic_pkg::CH_UP_A:ckic_pkg::CH_UP_Z],
                                  ckic_pkg::CH_USCORE};
    is_digit    = s1_ch_r inside {[ckic_pkg::CH_0:ckic_pkg::CH_9]};
  end

  assign is_end = s1_eot_r || is_space;

  ckic_kw_match u_kw_match (
    .ch       (s1_ch_r),
    .pos      (count_r),
    .cand     (cand_r),
    .cand_nxt (mask_upd),
    .kw_hit   (kw_hit)
  );

  always_comb begin
    in_token_nxt  = in_token_r;
    count_nxt     = count_r;
    ident_ok_nxt  = ident_ok_r;
    cand_nxt      = cand_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_class_nxt = out_class_r;
    out_len_nxt   = out_len_r;
    if (advance) begin
      if (is_end) begin
        if (in_token_r) begin
          // Keywords win over identifiers; other tokens are dropped.
          if (kw_hit || ident_ok_r) begin
            out_valid_nxt = 1'b1;
            out_class_nxt = kw_hit ? ckic_pkg::CLASS_KEYWORD
                                   : ckic_pkg::CLASS_IDENTIFIER;
            out_len_nxt   = count_r;
          end
          in_token_nxt = 1'b0;
          count_nxt    = '0;
          ident_ok_nxt = 1'b1;
          cand_nxt     = '1;
        end
      end else begin
        cand_nxt = mask_upd;
        if (count_r == '0) begin
          if (!is_alpha_us) ident_ok_nxt = 1'b0;
        end else if (!(is_alpha_us || is_digit)) begin
          ident_ok_nxt = 1'b0;
        end
        if (count_r != '1) count_nxt = count_r + 1'b1;
        in_token_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_token_r  <= 1'b0;
      count_r     <= '0;
      ident_ok_r  <= 1'b1;
      cand_r      <= '1;
      out_valid_r <= 1'b0;
    end else begin
      in_token_r  <= in_token_nxt;
      count_r     <= count_nxt;
      ident_ok_r  <= ident_ok_nxt;
      cand_r      <= cand_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_class_r <= out_class_nxt;
    out_len_r   <= out_len_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_len_r;
  assign out_tuser[0] = out_class_r;

endmodule

>>> hdl/ckic_checker.sv
// Port-level assertions for the classifier, bound to the top level.
module ckic_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [0:0] out_tuser
);

  // No result is pending right after a reset cycle.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A reported token always holds at least one character.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != 8'd0)
    else $error("zero-length token reported");

  // Keywords are two to eight characters long.
  a_kw_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0] == ckic_pkg::CLASS_KEYWORD) |->
      (out_tdata >= 8'd2 && out_tdata <= 8'd8))
    else $error("keyword with impossible length");

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind c_keyword_identifier_classifier ckic_checker u_ckic_checker (.*);
